### hdl/bpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boris particle push package
// Shared defaults and configuration register codes.
// ----------------------------------------------------------------------------
package bpp_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int FRAC_BITS_DEFAULT  = 20;
    localparam int CFG_INDEX_WIDTH    = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TIME_STEP         = 2'd0,
        REG_CHARGE_MASS_RATIO = 2'd1
    } reg_index_t;

endpackage

### hdl/bpp_particle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle channel
// Position, velocity and the fields at the particle, with valid and ready.
// ----------------------------------------------------------------------------
interface bpp_particle_if
    import bpp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] pos_z;
    logic signed [DATA_WIDTH-1:0] vel_x;
    logic signed [DATA_WIDTH-1:0] vel_y;
    logic signed [DATA_WIDTH-1:0] vel_z;
    logic signed [DATA_WIDTH-1:0] efield_x;
    logic signed [DATA_WIDTH-1:0] efield_y;
    logic signed [DATA_WIDTH-1:0] efield_z;
    logic signed [DATA_WIDTH-1:0] bfield_x;
    logic signed [DATA_WIDTH-1:0] bfield_y;
    logic signed [DATA_WIDTH-1:0] bfield_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
                    output ready);
endinterface

### hdl/bpp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Advanced position and updated velocity, with valid and ready.
// ----------------------------------------------------------------------------
interface bpp_result_if
    import bpp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] new_pos_x;
    logic signed [DATA_WIDTH-1:0] new_pos_y;
    logic signed [DATA_WIDTH-1:0] new_pos_z;
    logic signed [DATA_WIDTH-1:0] new_vel_x;
    logic signed [DATA_WIDTH-1:0] new_vel_y;
    logic signed [DATA_WIDTH-1:0] new_vel_z;

    modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                    new_vel_x, new_vel_y, new_vel_z, input ready);
    modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z,
                    new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

### hdl/bpp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, with valid and ready.
// ----------------------------------------------------------------------------
interface bpp_cfg_if
    import bpp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/boris_particle_push_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boris particle push unit
// Half electric kick, magnetic rotation, second half kick and position update
// for one particle per transaction, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Usage:
// Particles arrive on the particle channel and results leave on the result
// channel, one result transaction for every particle transaction, in order.
// The time step and charge over mass ratio are written through the cfg
// channel, which is always ready; write them only while no particle is in
// flight. Index 0 is the time step, index 1 the charge over mass ratio.
// A new particle can be taken in every cycle while the result channel
// takes results or a stage is empty. The depth is set by the divider for
// s = 2t / (1 + |t|^2), which resolves one quotient bit per stage over
// DATA_WIDTH + 1 stages. Each stage holds its item while the next one is
// full and held, so a stalled result channel fills the pipeline bubble by
// bubble before particle ready drops.
// Reset clears every stage valid bit and loads the default registers
// (time step about 0.01, charge over mass ratio -1.0).
// ----------------------------------------------------------------------------
module boris_particle_push_unit
    import bpp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    bpp_cfg_if.sink        cfg,
    bpp_particle_if.sink   particle,
    bpp_result_if.source   result
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QB = W + 1;
    localparam int NS = 10 + QB;
    localparam int ST_E = 4;
    localparam int ST_S = 5 + QB;
    localparam int ST_G = 6 + QB;
    localparam int ST_H = 7 + QB;
    localparam int ST_I = 8 + QB;
    localparam int ST_J = 9 + QB;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(64'd1 << F);
    localparam logic signed [2*W:0] MAX_WIDE = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W:0] MIN_WIDE = {{(W+2){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-2:0] DT_RESET = (W-1)'(((64'd1 << F) + 64'd50) / 64'd100);
    localparam logic [W-1:0] QM_RESET = W'(-(64'sd1 <<< F));

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W:0]   low;
        logic         neg;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]         lane;
        logic [W-1:0]        den;
        logic [2:0][W-1:0]   u;
        logic [2:0][W-1:0]   v1;
        logic [2:0][W-1:0]   ke;
        logic [2:0][W-1:0]   p;
        logic [W-2:0]        dt;
    } div_carry_t;

    function automatic logic signed [W-1:0] sat_wide(input logic signed [2*W:0] x);
        logic signed [W-1:0] y;
        if (x > MAX_WIDE)
            y = VMAX;
        else if (x < MIN_WIDE)
            y = VMIN;
        else
            y = x[W-1:0];
        return y;
    endfunction

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input int sh);
        logic signed [2*W-1:0] pr;
        logic signed [2*W:0]   ex;
        pr = a * b;
        ex = $signed({pr[2*W-1], pr}) >>> sh;
        return sat_wide(ex);
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic signed [W-1:0] y;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            y = s[W] ? VMIN : VMAX;
        else
            y = s[W-1:0];
        return y;
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic signed [W-1:0] y;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            y = s[W] ? VMIN : VMAX;
        else
            y = s[W-1:0];
        return y;
    endfunction

    function automatic lane_t div_step(input lane_t x, input logic [W-1:0] d);
        lane_t       y;
        logic [W:0]  r2;
        logic [W:0]  diff;
        r2   = {x.rem, x.low[W]};
        diff = r2 - {1'b0, d};
        y.neg = x.neg;
        if (r2 >= {1'b0, d})
        begin
            y.rem = diff[W-1:0];
            y.low = {x.low[W-1:0], 1'b1};
        end
        else
        begin
            y.rem = r2[W-1:0];
            y.low = {x.low[W-1:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic signed [W-1:0] div_pack(input lane_t x);
        logic [W+1:0]        m;
        logic signed [W-1:0] y;
        m = {1'b0, x.low} + {{(W+1){1'b0}}, (x.rem != '0)};
        if (!x.neg)
            y = (x.low > {1'b0, VMAX}) ? VMAX : x.low[W-1:0];
        else if (m > {3'b000, {(W-1){1'b0}}} + ({{(W+1){1'b0}}, 1'b1} << (W-1)))
            y = VMIN;
        else
            y = -$signed(m[W-1:0]);
        return y;
    endfunction

    // Configuration registers.
    logic [W-2:0] dt_reg;
    logic [W-1:0] qm_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= DT_RESET;
            qm_reg <= QM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TIME_STEP:         dt_reg <= cfg.data[W-2:0];
                REG_CHARGE_MASS_RATIO: qm_reg <= cfg.data;
                default:               ;
            endcase
        end
    end

    // Stage valid bits and the per-stage advance chain.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = result.ready;
        for (int i = NS - 1; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign particle.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= particle.valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Stage A: half kick factor h = qm * dt / 2.
    logic signed [W-1:0] h_a_reg;
    logic signed [W-1:0] p_a_reg [3];
    logic signed [W-1:0] v_a_reg [3];
    logic signed [W-1:0] e_a_reg [3];
    logic signed [W-1:0] b_a_reg [3];
    logic [W-2:0]        dt_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            h_a_reg    <= fmul($signed(qm_reg), $signed({1'b0, dt_reg}), F + 1);
            p_a_reg[0] <= particle.pos_x;
            p_a_reg[1] <= particle.pos_y;
            p_a_reg[2] <= particle.pos_z;
            v_a_reg[0] <= particle.vel_x;
            v_a_reg[1] <= particle.vel_y;
            v_a_reg[2] <= particle.vel_z;
            e_a_reg[0] <= particle.efield_x;
            e_a_reg[1] <= particle.efield_y;
            e_a_reg[2] <= particle.efield_z;
            b_a_reg[0] <= particle.bfield_x;
            b_a_reg[1] <= particle.bfield_y;
            b_a_reg[2] <= particle.bfield_z;
            dt_a_reg   <= dt_reg;
        end
    end

    // Stage B: electric kick and rotation vector t.
    logic signed [W-1:0] ke_b_reg [3];
    logic signed [W-1:0] t_b_reg  [3];
    logic signed [W-1:0] p_b_reg  [3];
    logic signed [W-1:0] v_b_reg  [3];
    logic [W-2:0]        dt_b_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                ke_b_reg[k] <= fmul(h_a_reg, e_a_reg[k], F);
                t_b_reg[k]  <= fmul(h_a_reg, b_a_reg[k], F);
                p_b_reg[k]  <= p_a_reg[k];
                v_b_reg[k]  <= v_a_reg[k];
            end
            dt_b_reg <= dt_a_reg;
        end
    end

    // Stage C: first kick applied, squares of t.
    logic signed [W-1:0] v1_c_reg [3];
    logic signed [W-1:0] tt_c_reg [3];
    logic signed [W-1:0] t_c_reg  [3];
    logic signed [W-1:0] ke_c_reg [3];
    logic signed [W-1:0] p_c_reg  [3];
    logic [W-2:0]        dt_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                v1_c_reg[k] <= sadd(v_b_reg[k], ke_b_reg[k]);
                tt_c_reg[k] <= fmul(t_b_reg[k], t_b_reg[k], F);
                t_c_reg[k]  <= t_b_reg[k];
                ke_c_reg[k] <= ke_b_reg[k];
                p_c_reg[k]  <= p_b_reg[k];
            end
            dt_c_reg <= dt_b_reg;
        end
    end

    // Stage D: cross products v x t and the denominator 1 + |t|^2.
    logic signed [W-1:0] x1_d_reg [3];
    logic signed [W-1:0] x2_d_reg [3];
    logic signed [W-1:0] den_d_reg;
    logic signed [W-1:0] t_d_reg  [3];
    logic signed [W-1:0] v1_d_reg [3];
    logic signed [W-1:0] ke_d_reg [3];
    logic signed [W-1:0] p_d_reg  [3];
    logic [W-2:0]        dt_d_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                x1_d_reg[k] <= fmul(v1_c_reg[(k+1)%3], t_c_reg[(k+2)%3], F);
                x2_d_reg[k] <= fmul(v1_c_reg[(k+2)%3], t_c_reg[(k+1)%3], F);
                t_d_reg[k]  <= t_c_reg[k];
                v1_d_reg[k] <= v1_c_reg[k];
                ke_d_reg[k] <= ke_c_reg[k];
                p_d_reg[k]  <= p_c_reg[k];
            end
            den_d_reg <= sadd(sadd(sadd(ONE, tt_c_reg[0]), tt_c_reg[1]), tt_c_reg[2]);
            dt_d_reg  <= dt_c_reg;
        end
    end

    // Stage E: u = v + v x t, and the divider set-up. The dividend is
    // |t| * 2^(F+1); its upper bits seed the remainder and the lower W+1
    // bits are shifted through, leaving the quotient behind.
    div_carry_t car_reg [0:QB];
    div_carry_t car_next;

    always_comb
    begin
        logic [W-1:0] a;
        car_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = t_d_reg[k][W-1] ? W'(-t_d_reg[k]) : W'(t_d_reg[k]);
            car_next.lane[k].neg = t_d_reg[k][W-1];
            car_next.lane[k].rem = W'(a >> (W - F));
            car_next.lane[k].low = (W+1)'({1'b0, a} << (F + 1));
            car_next.u[k]  = ssub(sadd(v1_d_reg[k], x1_d_reg[k]), x2_d_reg[k]);
            car_next.v1[k] = v1_d_reg[k];
            car_next.ke[k] = ke_d_reg[k];
            car_next.p[k]  = p_d_reg[k];
        end
        // The denominator is at least one by construction; clip anyway.
        car_next.den = (den_d_reg < $signed({{(W-1){1'b0}}, 1'b1})) ?
                       {{(W-1){1'b0}}, 1'b1} : den_d_reg;
        car_next.dt  = dt_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E])
            car_reg[0] <= car_next;
    end

    // Divider stages, one quotient bit per lane and stage.
    for (genvar g = 1; g <= QB; g++)
    begin : g_div
        div_carry_t step_next;

        always_comb
        begin
            step_next = car_reg[g-1];
            for (int k = 0; k < 3; k++)
                step_next.lane[k] = div_step(car_reg[g-1].lane[k], car_reg[g-1].den);
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_E + g])
                car_reg[g] <= step_next;
        end
    end

    // Stage S: round and saturate s.
    logic signed [W-1:0] s_s_reg  [3];
    logic signed [W-1:0] u_s_reg  [3];
    logic signed [W-1:0] v1_s_reg [3];
    logic signed [W-1:0] ke_s_reg [3];
    logic signed [W-1:0] p_s_reg  [3];
    logic [W-2:0]        dt_s_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_S])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_s_reg[k]  <= div_pack(car_reg[QB].lane[k]);
                u_s_reg[k]  <= car_reg[QB].u[k];
                v1_s_reg[k] <= car_reg[QB].v1[k];
                ke_s_reg[k] <= car_reg[QB].ke[k];
                p_s_reg[k]  <= car_reg[QB].p[k];
            end
            dt_s_reg <= car_reg[QB].dt;
        end
    end

    // Stage G: cross products u x s.
    logic signed [W-1:0] y1_g_reg [3];
    logic signed [W-1:0] y2_g_reg [3];
    logic signed [W-1:0] v1_g_reg [3];
    logic signed [W-1:0] ke_g_reg [3];
    logic signed [W-1:0] p_g_reg  [3];
    logic [W-2:0]        dt_g_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_G])
        begin
            for (int k = 0; k < 3; k++)
            begin
                y1_g_reg[k] <= fmul(u_s_reg[(k+1)%3], s_s_reg[(k+2)%3], F);
                y2_g_reg[k] <= fmul(u_s_reg[(k+2)%3], s_s_reg[(k+1)%3], F);
                v1_g_reg[k] <= v1_s_reg[k];
                ke_g_reg[k] <= ke_s_reg[k];
                p_g_reg[k]  <= p_s_reg[k];
            end
            dt_g_reg <= dt_s_reg;
        end
    end

    // Stage H: rotated velocity plus the second half kick.
    logic signed [W-1:0] nv_h_reg [3];
    logic signed [W-1:0] p_h_reg  [3];
    logic [W-2:0]        dt_h_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_H])
        begin
            for (int k = 0; k < 3; k++)
            begin
                nv_h_reg[k] <= sadd(ssub(sadd(v1_g_reg[k], y1_g_reg[k]), y2_g_reg[k]),
                                    ke_g_reg[k]);
                p_h_reg[k]  <= p_g_reg[k];
            end
            dt_h_reg <= dt_g_reg;
        end
    end

    // Stage I: displacement v * dt.
    logic signed [W-1:0] dp_i_reg [3];
    logic signed [W-1:0] nv_i_reg [3];
    logic signed [W-1:0] p_i_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_I])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dp_i_reg[k] <= fmul(nv_h_reg[k], $signed({1'b0, dt_h_reg}), F);
                nv_i_reg[k] <= nv_h_reg[k];
                p_i_reg[k]  <= p_h_reg[k];
            end
        end
    end

    // Stage J: output register.
    logic signed [W-1:0] np_j_reg [3];
    logic signed [W-1:0] nv_j_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_J])
        begin
            for (int k = 0; k < 3; k++)
            begin
                np_j_reg[k] <= sadd(p_i_reg[k], dp_i_reg[k]);
                nv_j_reg[k] <= nv_i_reg[k];
            end
        end
    end

    assign result.valid     = vld_reg[ST_J];
    assign result.new_pos_x = np_j_reg[0];
    assign result.new_pos_y = np_j_reg[1];
    assign result.new_pos_z = np_j_reg[2];
    assign result.new_vel_x = nv_j_reg[0];
    assign result.new_vel_y = nv_j_reg[1];
    assign result.new_vel_z = nv_j_reg[2];

    // The input side only backs up once every stage holds an item.
    a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        !particle.ready |-> (&vld_reg))
        else $error("particle ready low with an empty stage");

    a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
        (particle.valid && particle.ready) |=> vld_reg[0])
        else $error("accepted particle did not enter the first stage");

    a_den_at_least_one : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (den_d_reg >= ONE))
        else $error("rotation denominator below one");

    a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (vld_reg[ST_J] && !en[ST_J]) ||
                                            result.ready)
        else $error("stalled result stage was overwritten");

endmodule

### tb/tb_boris_particle_push_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boris particle push unit testbench
// Drives particles with random bursts and gaps, stalls the result channel,
// predicts each push in fixed point and checks every result transaction in
// order against the prediction, over several register settings.
// ----------------------------------------------------------------------------

class push_scoreboard;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
    } push_result_t;

    push_result_t pending [$];
    longint       dt;
    longint       qm;
    int           errors;
    int           checked;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    function new();
        dt      = 10486;
        qm      = -1048576;
        errors  = 0;
        checked = 0;
    endfunction

    function longint clip(logic signed [127:0] x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return longint'(x);
    endfunction

    // Arithmetic shift of the exact product gives floor rounding.
    function longint fx_mul(longint a, longint b, int sh);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clip(p >>> sh);
    endfunction

    function longint fx_add(longint a, longint b);
        return clip(128'(a) + 128'(b));
    endfunction

    function longint fx_sub(longint a, longint b);
        return clip(128'(a) - 128'(b));
    endfunction

    function longint fx_div2(longint t, longint d);
        logic signed [127:0] num;
        logic signed [127:0] q;
        longint              ud;
        ud  = d < 1 ? 1 : d;
        num = 128'(t) <<< 21;
        q   = num / ud;
        if (num < 0 && q * ud != num) q = q - 1;
        return clip(q);
    endfunction

    function void note_particle(longint p [3], longint v [3], longint e [3],
                                longint b [3]);
        longint       h, den;
        longint       ke [3], t [3], u [3], s [3], w [3], vv [3];
        longint       nv;
        push_result_t r;
        int           k1, k2;
        h = fx_mul(qm, dt, 21);
        for (int k = 0; k < 3; k++)
        begin
            ke[k] = fx_mul(h, e[k], 20);
            vv[k] = fx_add(v[k], ke[k]);
            t[k]  = fx_mul(h, b[k], 20);
        end
        for (int k = 0; k < 3; k++)
        begin
            k1 = (k + 1) % 3;
            k2 = (k + 2) % 3;
            u[k] = fx_sub(fx_add(vv[k], fx_mul(vv[k1], t[k2], 20)),
                          fx_mul(vv[k2], t[k1], 20));
        end
        den = 1 << 20;
        for (int k = 0; k < 3; k++)
            den = fx_add(den, fx_mul(t[k], t[k], 20));
        for (int k = 0; k < 3; k++)
            s[k] = fx_div2(t[k], den);
        for (int k = 0; k < 3; k++)
        begin
            k1 = (k + 1) % 3;
            k2 = (k + 2) % 3;
            w[k] = fx_sub(fx_add(vv[k], fx_mul(u[k1], s[k2], 20)),
                          fx_mul(u[k2], s[k1], 20));
        end
        for (int k = 0; k < 3; k++)
        begin
            nv       = fx_add(w[k], ke[k]);
            r.vel[k] = nv[31:0];
            r.pos[k] = 32'(fx_add(p[k], fx_mul(nv, dt, 20)));
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] pos [3],
                               logic signed [31:0] vel [3]);
        push_result_t exp_r;
        string        axis;
        if (pending.size() == 0)
        begin
            $error("result transaction with no particle outstanding");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        for (int k = 0; k < 3; k++)
        begin
            axis = k == 0 ? "x" : (k == 1 ? "y" : "z");
            if (pos[k] !== exp_r.pos[k])
            begin
                $error("new_pos_%s: expected %0d, got %0d", axis, exp_r.pos[k], pos[k]);
                errors++;
            end
            if (vel[k] !== exp_r.vel[k])
            begin
                $error("new_vel_%s: expected %0d, got %0d", axis, exp_r.vel[k], vel[k]);
                errors++;
            end
        end
    endfunction

endclass

module tb_boris_particle_push_unit;
    import bpp_pkg::*;

    localparam int LATENCY    = 43;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpp_cfg_if      cfg ();
    bpp_particle_if particle ();
    bpp_result_if   result ();

    boris_particle_push_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg.sink),
        .particle (particle.sink),
        .result   (result.source)
    );

    push_scoreboard board = new();
    int  sent = 0;
    bit  long_hold = 1'b0;
    int  idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        cfg.valid      = 1'b0;
        cfg.index      = REG_TIME_STEP;
        cfg.data       = '0;
        particle.valid = 1'b0;
        {particle.pos_x, particle.pos_y, particle.pos_z} = '0;
        {particle.vel_x, particle.vel_y, particle.vel_z} = '0;
        {particle.efield_x, particle.efield_y, particle.efield_z} = '0;
        {particle.bfield_x, particle.bfield_y, particle.bfield_z} = '0;
        result.ready   = 1'b0;
    end

    // Result side: stalls on its own pattern, plus one long hold-off.
    always @(posedge clk)
    begin
        if (long_hold)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(0, 15) < 3) ? 1'b0 :
                            ((sent / 200) % 2 == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        if (rst_n && result.valid && result.ready)
        begin
            pos = '{result.new_pos_x, result.new_pos_y, result.new_pos_z};
            vel = '{result.new_vel_x, result.new_vel_y, result.new_vel_z};
            board.check_result(pos, vel);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((particle.valid && particle.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_TIME_STEP)
            board.dt = longint'(value[30:0]);
        else
            board.qm = longint'($signed(value));
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default:
            begin
                if (mode == 0)
                    return $urandom();
                return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20)) <<< $urandom_range(0, 6);
            end
        endcase
    endfunction

    // Offers one particle and holds it until accepted.
    task automatic send_particle(logic [31:0] f [12]);
        longint p [3], v [3], e [3], b [3];
        particle.valid    <= 1'b1;
        particle.pos_x    <= f[0];
        particle.pos_y    <= f[1];
        particle.pos_z    <= f[2];
        particle.vel_x    <= f[3];
        particle.vel_y    <= f[4];
        particle.vel_z    <= f[5];
        particle.efield_x <= f[6];
        particle.efield_y <= f[7];
        particle.efield_z <= f[8];
        particle.bfield_x <= f[9];
        particle.bfield_y <= f[10];
        particle.bfield_z <= f[11];
        do @(posedge clk); while (!particle.ready);
        for (int k = 0; k < 3; k++)
        begin
            p[k] = longint'($signed(f[k]));
            v[k] = longint'($signed(f[3 + k]));
            e[k] = longint'($signed(f[6 + k]));
            b[k] = longint'($signed(f[9 + k]));
        end
        board.note_particle(p, v, e, b);
        sent++;
    endtask

    task automatic random_run(int count, int mode);
        logic [31:0] f [12];
        int          burst;
        int          left;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                foreach (f[j])
                    f[j] = pick_value(mode);
                send_particle(f);
                left--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                particle.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        particle.valid <= 1'b0;
    endtask

    task automatic drain();
        particle.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] f [12];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero fields, field extremes and saturation corners.
        for (int d = 0; d < 20; d++)
        begin
            foreach (f[j])
            begin
                case (d % 5)
                    0: f[j] = 32'h0;
                    1: f[j] = 32'h7fff_ffff;
                    2: f[j] = 32'h8000_0000;
                    3: f[j] = (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
                    default: f[j] = 32'h0010_0000 << (j % 4);
                endcase
                if (d >= 10)
                    f[j] = ~f[j];
            end
            send_particle(f);
        end
        particle.valid <= 1'b0;
        drain();

        // Long receiver hold-off while particles keep coming.
        long_hold = 1'b1;
        fork
            random_run(120, 1);
            begin
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
        join
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_TIME_STEP, 32'h7fff_ffff);
                         write_reg(REG_CHARGE_MASS_RATIO, 32'h7fff_ffff); end
                1: begin write_reg(REG_TIME_STEP, 32'h0);
                         write_reg(REG_CHARGE_MASS_RATIO, 32'h8000_0000); end
                2: begin write_reg(REG_TIME_STEP, 32'h0010_0000);
                         write_reg(REG_CHARGE_MASS_RATIO, 32'h0020_0000); end
                3: begin write_reg(REG_TIME_STEP, 32'hffff_ffff);
                         write_reg(REG_CHARGE_MASS_RATIO, 32'h0); end
                4: begin write_reg(REG_TIME_STEP, $urandom());
                         write_reg(REG_CHARGE_MASS_RATIO, $urandom()); end
                default: begin write_reg(REG_TIME_STEP, 32'd10486);
                               write_reg(REG_CHARGE_MASS_RATIO, -32'sd1048576); end
            endcase
            random_run(80, 0);
            random_run(110, 1);
            drain();
        end

        $display("Covered %0d particles over 7 register settings, %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
